// ===== rtl/fmbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbf_pkg
// Shared widths, character codes and types for the front matter boundary
// finder.
// ----------------------------------------------------------------------------
package fmbf_pkg;

  // Byte position counter width (valid range 8 to 32)
  localparam int POSITION_BITS = 24;
  // Width of the reported body offset
  localparam int OFFSET_BITS   = 24;
  // Common width for comparing positions against the offset ceiling
  localparam int WIDE_BITS     = 33;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  // Character codes
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;

  // Delimiter line length, and the value line length holds at
  localparam logic [2:0] DELIM_LEN = 3'd3;
  localparam logic [2:0] LEN_HOLD  = 3'd4;

  // One result beat
  typedef struct packed {
    logic                   has_front_matter;
    logic [OFFSET_BITS-1:0] body_offset;
    logic                   length_overflow;
  } result_t;

endpackage

// ===== rtl/fmbf_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbf_scan
// Line splitter and delimiter tracker. Holds the parse state, advances it by
// one byte when step is high and forms the result for a final byte.
// ----------------------------------------------------------------------------
module fmbf_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           text_byte,
  input  logic                 is_final,
  output fmbf_pkg::result_t    result
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SEARCH = 2'd1;
  localparam logic [1:0] PH_FOUND  = 2'd2;
  localparam logic [1:0] PH_NONE   = 2'd3;

  localparam int PB = fmbf_pkg::POSITION_BITS;
  localparam int WB = fmbf_pkg::WIDE_BITS;

  logic [1:0]    phase_r, phase_nxt;
  logic [2:0]    len_r, len_nxt;
  logic          dash_r, dash_nxt;
  logic          dot_r, dot_nxt;
  logic          cr_r, cr_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [PB-1:0] body_r, body_nxt;
  logic          ovf_r, ovf_nxt;

  logic          is_term;
  logic          swallow;
  logic          at_max;
  logic [WB-1:0] body_wide;

  // Next state for one byte
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    dash_nxt  = dash_r;
    dot_nxt   = dot_r;
    cr_nxt    = 1'b0;
    body_nxt  = body_r;

    is_term = (text_byte == fmbf_pkg::CHAR_LF) || (text_byte == fmbf_pkg::CHAR_CR);
    swallow = cr_r && (text_byte == fmbf_pkg::CHAR_LF);

    // saturating byte counter
    at_max  = (pos_r == {PB{1'b1}});
    pos_nxt = at_max ? pos_r : pos_r + PB'(1);
    ovf_nxt = ovf_r | at_max;

    if (phase_r == PH_FOUND) begin
      // LF completing the closing line's CRLF moves the body one on
      if (swallow) begin
        body_nxt = pos_nxt;
      end
    end else if ((phase_r != PH_NONE) && !swallow) begin
      if (is_term) begin
        if (phase_r == PH_FIRST) begin
          phase_nxt = (len_r == fmbf_pkg::DELIM_LEN && dash_r) ? PH_SEARCH : PH_NONE;
        end else if (len_r == fmbf_pkg::DELIM_LEN && (dash_r || dot_r)) begin
          phase_nxt = PH_FOUND;
          body_nxt  = pos_nxt;
        end
        cr_nxt   = (text_byte == fmbf_pkg::CHAR_CR);
        len_nxt  = 3'd0;
        dash_nxt = 1'b1;
        dot_nxt  = 1'b1;
      end else begin
        dash_nxt = dash_r && (text_byte == fmbf_pkg::CHAR_DASH);
        dot_nxt  = dot_r && (text_byte == fmbf_pkg::CHAR_DOT);
        len_nxt  = (len_r < fmbf_pkg::LEN_HOLD) ? len_r + 3'd1 : len_r;
        // unterminated closing line on the final byte
        if (is_final && phase_r == PH_SEARCH &&
            len_nxt == fmbf_pkg::DELIM_LEN && (dash_nxt || dot_nxt)) begin
          phase_nxt = PH_FOUND;
          body_nxt  = pos_nxt;
        end
      end
    end
  end

  // Result from the updated state, offset clamped to the output width
  always_comb begin
    body_wide               = WB'(body_nxt);
    result.has_front_matter = (phase_nxt == PH_FOUND);
    result.length_overflow  = ovf_nxt;
    if (phase_nxt != PH_FOUND) begin
      result.body_offset = '0;
    end else if (body_wide > WB'(fmbf_pkg::OFFSET_MAX)) begin
      result.body_offset = fmbf_pkg::OFFSET_MAX;
    end else begin
      result.body_offset = fmbf_pkg::OFFSET_BITS'(body_wide);
    end
  end

  // State registers; everything clears after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_final)) begin
      phase_r <= PH_FIRST;
      len_r   <= 3'd0;
      dash_r  <= 1'b1;
      dot_r   <= 1'b1;
      cr_r    <= 1'b0;
      pos_r   <= '0;
      body_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      dash_r  <= dash_nxt;
      dot_r   <= dot_nxt;
      cr_r    <= cr_nxt;
      pos_r   <= pos_nxt;
      body_r  <= body_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== rtl/front_matter_boundary_finder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_matter_boundary_finder_core
// Finds the end of a "---" front matter block in a byte stream and reports
// the body offset once per document.
//
//   channel   ports                               beat
//   --------  ----------------------------------  ---------------------------
//   in        in_valid/in_ready, in_text_byte,    one document byte
//             in_is_final
//   out       out_valid/out_ready,                one result per document
//             out_has_front_matter,
//             out_body_offset, out_length_overflow
//
// One byte per cycle sustained while no stalled result holds back a final
// byte; a final byte passes through the input register, then the scan logic
// loads the result register, which raises the result beat.
// Synchronous active-low reset clears the pipeline and the parse state.
// A stalled result only holds back a final byte waiting in the input
// register; ordinary bytes keep flowing while a result waits.
// ----------------------------------------------------------------------------
module front_matter_boundary_finder_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_text_byte,
  input  logic                             in_is_final,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_has_front_matter,
  output logic [fmbf_pkg::OFFSET_BITS-1:0] out_body_offset,
  output logic                             out_length_overflow
);

  logic              in_vld_r, in_vld_nxt;
  logic [7:0]        in_byte_r;
  logic              in_final_r;
  logic              out_vld_r, out_vld_nxt;
  fmbf_pkg::result_t res_r;
  fmbf_pkg::result_t scan_res;
  logic              out_stall;
  logic              proc_fire;
  logic              out_load;

  // Stage handshakes
  assign out_stall  = out_vld_r && !out_ready;
  assign proc_fire  = in_vld_r && (!in_final_r || !out_stall);
  assign out_load   = proc_fire && in_final_r;
  assign in_ready   = !in_vld_r || proc_fire;
  assign in_vld_nxt = (in_valid && in_ready) || (in_vld_r && !proc_fire);
  assign out_vld_nxt = out_load || out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r  <= in_text_byte;
      in_final_r <= in_is_final;
    end
  end

  // Parse state and result forming
  fmbf_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc_fire),
    .text_byte (in_byte_r),
    .is_final  (in_final_r),
    .result    (scan_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= scan_res;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_has_front_matter = res_r.has_front_matter;
  assign out_body_offset      = res_r.body_offset;
  assign out_length_overflow  = res_r.length_overflow;

  // Only a final byte facing a stalled result may block the input
  a_block_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && in_final_r && out_stall))
    else $error("input blocked without a pending final byte");

  // No front matter always reports a zero offset
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.has_front_matter || res_r.body_offset == '0))
    else $error("non-zero offset without front matter");

  // A non-final byte never creates a result beat
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && !in_final_r && !out_vld_r) |=> !out_vld_r)
    else $error("result raised by a non-final byte");

endmodule

// ===== tb/sv/fmbf_offset_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbf_offset_checker
// Watches both channels of the front matter boundary finder. Every byte beat
// taken on the input runs through a line scanner of its own. On the final
// byte of a document that scanner queues the result it expects. Every result
// beat is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module fmbf_offset_checker
  import fmbf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_is_final,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_has_front_matter,
  input  logic [OFFSET_BITS-1:0] out_body_offset,
  input  logic                   out_length_overflow,
  output int                     mismatch_count,
  output int                     results_awaited
);

  typedef enum logic [1:0] {
    FIND_OPEN  = 2'd0,
    FIND_CLOSE = 2'd1,
    CLOSE_SEEN = 2'd2,
    NO_FRONT   = 2'd3
  } scan_phase_t;

  // Scanner state for the document in flight
  scan_phase_t              phase;
  logic [2:0]               line_len;
  logic                     dash_only;
  logic                     dot_only;
  logic                     cr_ended_line;
  logic [POSITION_BITS-1:0] byte_count;
  logic [POSITION_BITS-1:0] body_at;
  logic                     count_saturated;

  result_t awaited_results[$];

  function automatic void clear_scan();
    phase           = FIND_OPEN;
    line_len        = '0;
    dash_only       = 1'b1;
    dot_only        = 1'b1;
    cr_ended_line   = 1'b0;
    byte_count      = '0;
    body_at         = '0;
    count_saturated = 1'b0;
  endfunction

  // Current line is exactly three dashes, or three dots where allowed
  function automatic logic line_is_marker(input logic dots_allowed);
    return (line_len == DELIM_LEN) && (dash_only || (dots_allowed && dot_only));
  endfunction

  // Advance the scanner by one byte; queue a result on the final byte
  function automatic void track_document_byte(input logic [7:0] b, input logic last);
    logic [POSITION_BITS-1:0] pos_next;
    logic [WIDE_BITS-1:0]     wide_body;
    logic                     ends_line;
    logic                     lf_of_crlf;
    result_t                  want;

    ends_line  = (b == CHAR_LF) || (b == CHAR_CR);
    lf_of_crlf = cr_ended_line && (b == CHAR_LF);

    if (byte_count == {POSITION_BITS{1'b1}}) begin
      pos_next        = byte_count;
      count_saturated = 1'b1;
    end else begin
      pos_next = byte_count + 1'b1;
    end
    byte_count = pos_next;

    cr_ended_line = 1'b0;
    if (phase == CLOSE_SEEN) begin
      // LF completing the closing line's CRLF moves the body on by one
      if (lf_of_crlf) body_at = pos_next;
    end else if (phase != NO_FRONT && !lf_of_crlf) begin
      if (ends_line) begin
        if (phase == FIND_OPEN) begin
          phase = line_is_marker(1'b0) ? FIND_CLOSE : NO_FRONT;
        end else if (line_is_marker(1'b1)) begin
          phase   = CLOSE_SEEN;
          body_at = pos_next;
        end
        cr_ended_line = (b == CHAR_CR);
        line_len      = '0;
        dash_only     = 1'b1;
        dot_only      = 1'b1;
      end else begin
        if (b != CHAR_DASH) dash_only = 1'b0;
        if (b != CHAR_DOT) dot_only = 1'b0;
        if (line_len < LEN_HOLD) line_len = line_len + 1'b1;
        // unterminated closing line at the end of the document
        if (last && phase == FIND_CLOSE && line_is_marker(1'b1)) begin
          phase   = CLOSE_SEEN;
          body_at = pos_next;
        end
      end
    end

    if (last) begin
      wide_body = WIDE_BITS'(body_at);
      if (phase == CLOSE_SEEN) begin
        want.has_front_matter = 1'b1;
        if (wide_body > WIDE_BITS'(OFFSET_MAX)) want.body_offset = OFFSET_MAX;
        else want.body_offset = OFFSET_BITS'(wide_body);
      end else begin
        want.has_front_matter = 1'b0;
        want.body_offset      = '0;
      end
      want.length_overflow = count_saturated;
      awaited_results.push_back(want);
      clear_scan();
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_scan();
      awaited_results.delete();
    end else begin
      // result beat first: it always belongs to an earlier document
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got fm=%0b offset=%0d ovf=%0b",
                   $time, out_has_front_matter, out_body_offset, out_length_overflow);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (out_has_front_matter !== want.has_front_matter) begin
            $display("%0t: has_front_matter expected %0b, got %0b",
                     $time, want.has_front_matter, out_has_front_matter);
            mismatch_count = mismatch_count + 1;
          end
          if (out_body_offset !== want.body_offset) begin
            $display("%0t: body_offset expected %0d, got %0d",
                     $time, want.body_offset, out_body_offset);
            mismatch_count = mismatch_count + 1;
          end
          if (out_length_overflow !== want.length_overflow) begin
            $display("%0t: length_overflow expected %0b, got %0b",
                     $time, want.length_overflow, out_length_overflow);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready) track_document_byte(in_text_byte, in_is_final);
    end
    results_awaited <= awaited_results.size();
  end

endmodule

// ===== tb/sv/front_matter_boundary_finder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// front_matter_boundary_finder_core_tb
// Feeds documents byte by byte into the boundary finder: a few hand-built
// documents for the edge cases, then random ones, mostly with a front matter
// block and random line endings, plus some pure noise. Sender gaps and
// receiver stalls vary by phase; the checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module front_matter_boundary_finder_core_tb;
  import fmbf_pkg::*;

  localparam int RANDOM_BYTES = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int END_SETTLE   = 4;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_text_byte;
  logic                   in_is_final;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_has_front_matter;
  logic [OFFSET_BITS-1:0] out_body_offset;
  logic                   out_length_overflow;

  int mismatch_count;
  int results_awaited;
  int cycle_count   = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 52;
  int bytes_sent;

  logic [7:0] doc_bytes[$];

  front_matter_boundary_finder_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_text_byte        (in_text_byte),
    .in_is_final         (in_is_final),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_has_front_matter(out_has_front_matter),
    .out_body_offset     (out_body_offset),
    .out_length_overflow (out_length_overflow)
  );

  fmbf_offset_checker offset_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_text_byte        (in_text_byte),
    .in_is_final         (in_is_final),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_has_front_matter(out_has_front_matter),
    .out_body_offset     (out_body_offset),
    .out_length_overflow (out_length_overflow),
    .mismatch_count      (mismatch_count),
    .results_awaited     (results_awaited)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Document building
  // --------------------------------------------------------------------------
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endfunction

  function automatic void add_line_end();
    case ($urandom_range(2))
      0: doc_bytes.push_back(CHAR_LF);
      1: doc_bytes.push_back(CHAR_CR);
      default: begin
        doc_bytes.push_back(CHAR_CR);
        doc_bytes.push_back(CHAR_LF);
      end
    endcase
  endfunction

  // Biased towards dashes and dots so near-miss markers turn up often
  function automatic logic [7:0] content_byte();
    case ($urandom_range(9))
      0, 1, 2: return CHAR_DASH;
      3, 4:    return CHAR_DOT;
      5:       return 8'h20;
      6, 7:    return 8'h61 + 8'($urandom_range(25));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_content(input int n);
    for (int i = 0; i < n; i++) doc_bytes.push_back(content_byte());
  endfunction

  // Exact markers and near misses
  function automatic void add_marker();
    case ($urandom_range(9))
      0, 1, 2, 3: add_text("---");
      4, 5:       add_text("...");
      6:          add_text("--");
      7:          add_text("----");
      8:          add_text("-.-");
      default:    add_content($urandom_range(4));
    endcase
  endfunction

  function automatic void build_random_doc();
    int body_len;
    if ($urandom_range(99) < 25) begin
      // noise: line ends and markers chars mixed with any byte
      for (int i = $urandom_range(11, 0); i >= 0; i--) begin
        case ($urandom_range(5))
          0:       doc_bytes.push_back(CHAR_LF);
          1:       doc_bytes.push_back(CHAR_CR);
          2:       doc_bytes.push_back(CHAR_DASH);
          default: doc_bytes.push_back(8'($urandom_range(255)));
        endcase
      end
    end else begin
      // opening line, a few inner lines, closing line, body
      if ($urandom_range(99) < 85) add_text("---");
      else add_marker();
      add_line_end();
      for (int i = $urandom_range(3); i > 0; i--) begin
        if ($urandom_range(99) < 30) add_marker();
        else add_content($urandom_range(6));
        add_line_end();
      end
      if ($urandom_range(99) < 75) add_text($urandom_range(1) ? "---" : "...");
      else add_marker();
      body_len = $urandom_range(99) < 35 ? 0 : $urandom_range(8, 1);
      if (body_len != 0 || $urandom_range(99) < 70) add_line_end();
      for (int i = 0; i < body_len; i++) begin
        if ($urandom_range(5) == 0) doc_bytes.push_back($urandom_range(1) ? CHAR_LF : CHAR_CR);
        else doc_bytes.push_back(content_byte());
      end
    end
    if (doc_bytes.size() == 0) doc_bytes.push_back(8'h78);
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_is_final  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_bytes.size(); i++) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    bytes_sent += doc_bytes.size();
    doc_bytes.delete();
  endtask

  // Hold off the sender until every queued result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_text_byte <= '0;
    in_is_final  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // closing line followed by body bytes
    add_text("---");
    doc_bytes.push_back(CHAR_LF);
    add_text("---");
    doc_bytes.push_back(CHAR_LF);
    add_text("x");
    send_doc();
    // dot closing line ended by CR, its LF swallowed into the terminator
    add_text("---");
    doc_bytes.push_back(CHAR_CR);
    add_text("...");
    doc_bytes.push_back(CHAR_CR);
    doc_bytes.push_back(CHAR_LF);
    send_doc();
    // unterminated closing line at the very end
    add_text("---");
    doc_bytes.push_back(CHAR_LF);
    add_text("---");
    send_doc();
    // opening line only
    add_text("---");
    send_doc();
    // single-byte documents at both byte extremes
    doc_bytes.push_back(8'hFF);
    send_doc();
    doc_bytes.push_back(8'h00);
    send_doc();
    wait_for_results();

    // random documents in three idling phases
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= 2 * RANDOM_BYTES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (bytes_sent >= RANDOM_BYTES / 3 && send_idle_pct == 14) begin
        wait_for_results();
        send_idle_pct = 52;
        recv_idle_pct = 14;
      end
      build_random_doc();
      send_doc();
    end

    wait_for_results();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && results_awaited == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
